// File: hw/rtl/mafg_pkg.sv
// Shared widths, defaults and saturation helper for the Mie angular function generator.
// Used by mie_angular_function_generator_unit; depends on nothing else.
`default_nettype none

package mafg_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_ORDERS    = 64;
  localparam int DEF_FRACTION_BITS = 24;

  // Field widths.
  localparam int COS_W   = 26;
  localparam int VAL_W   = 40;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 88;

  // Shared magnitude multiplier: cosine magnitude times one half of a value magnitude.
  localparam int MB_LO_W = 20;
  localparam int MB_HI_W = VAL_W - MB_LO_W;
  localparam int MUL_W   = COS_W + MB_LO_W;
  localparam int PROD_W  = COS_W + VAL_W;
  localparam int MAG_W   = VAL_W + 1;
  localparam int MRES_W  = MAG_W + 1;

  // Small coefficient scaler and accumulator.
  localparam int COEF_W  = CNT_W + 1;
  localparam int SC_OP_W = MRES_W + 1;
  localparam int SC_W    = COEF_W + SC_OP_W;
  localparam int ACC_W   = 50;

  // Divider by the order index: several quotient bits per cycle.
  localparam int DIV_STEP  = 8;
  localparam int DIV_ITERS = 7;
  localparam int DQ_W      = DIV_STEP * DIV_ITERS;
  localparam int DCNT_W    = $clog2(DIV_ITERS);
  localparam int DVS_W     = 6;

  localparam int SAT_IN_W = DQ_W + 2;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Clamp a wide signed value to the signed 40-bit result range.
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SAT_IN_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > SAT_IN_W'(VAL_MAX)) begin
      r = VAL_MAX;
    end else if (v < SAT_IN_W'(VAL_MIN)) begin
      r = VAL_MIN;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mie_angular_function_generator_unit.sv
// Mie angular function generator: pi_n and tau_n by upward recurrence, fixed point.
// Top level; depends on mafg_pkg.
`default_nettype none

// How to use this block.
// The input stream (s_tvalid, s_tready, s_tdata) carries one beat per scattering
// angle: the cosine mu in two's complement with FRACTION_BITS fraction bits.
// For each angle the output stream (m_tvalid, m_tready, m_tdata, m_tlast) gives
// order_count beats, one per order n = 1 .. order_count, each with n - 1, pi_n and
// tau_n; m_tlast is high on the final order of the run.
// The cfg channel (cfg_valid, cfg_ready, cfg_data) sets order_count. It is always
// ready; values below 2 are stored as 2 and values above MAX_ORDERS as MAX_ORDERS.
// Write it only while the block is idle.
// Timing: one small sequencer drives a shared 26 x 20 bit magnitude multiplier and a
// divider that retires eight quotient bits per cycle. Order 1 goes straight to the emit
// step, order 2 takes one multiplication and a coefficient step, and every later order
// takes two multiplications of two passes each, a divider run and the coefficient and
// emit steps. After the accepting cycle s_tready stays low while the angle is in progress.
// A result sits in an output register; if the receiver stalls, the sequencer finishes
// the next order and then waits until that register frees up. The input is taken again
// as soon as the final beat is in the register.
// Reset sets order_count to MAX_ORDERS (64 by default) and empties the output register.
module mie_angular_function_generator_unit
  import mafg_pkg::*;
#(
  parameter int MAX_ORDERS    = DEF_MAX_ORDERS,    // 2 .. 64
  parameter int FRACTION_BITS = DEF_FRACTION_BITS  // 16 .. 24
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Configuration write: order_count.
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CNT_W-1:0]    cfg_data,
  // Angle input.
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // [25:0] cos_angle, [31:26] zero
  // Result output.
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,   // [5:0] order_index, [45:6] pi_value,
                                              // [85:46] tau_value, [87:86] zero
  output logic                     m_tlast    // last_order
);

  typedef enum logic [3:0] {
    S_IDLE, S_ORDER, S_MUL_HI, S_MUL_LO, S_MUL_RND, S_SQUARE, S_NUM_A, S_NUM_B,
    S_DIV_SET, S_DIV, S_PI, S_TAU_A, S_TAU_B, S_EMIT
  } state_t;

  // What the current multiplication result is used for.
  typedef enum logic [1:0] {
    MS_SQUARE, MS_PREV, MS_PI
  } mul_sel_t;

  localparam logic signed [VAL_W-1:0] ONE = VAL_W'(1) << FRACTION_BITS;
  localparam logic [PROD_W:0]         RND_HALF = (PROD_W+1)'(1) << (FRACTION_BITS - 1);

  state_t                     state;
  logic [CNT_W-1:0]           order_count;
  logic [CNT_W-1:0]           n;
  logic signed [COS_W-1:0]    held_cosine;
  logic signed [VAL_W-1:0]    pi_previous;
  logic signed [VAL_W-1:0]    pi_before_previous;
  logic signed [VAL_W-1:0]    cur_pi;

  logic [COS_W-1:0]           mul_a;
  logic [VAL_W-1:0]           mul_b;
  logic                       mul_neg;
  mul_sel_t                   mul_sel;
  logic [PROD_W-1:0]          prod;
  logic signed [MRES_W-1:0]   mres;
  logic signed [ACC_W-1:0]    acc;

  logic [DQ_W-1:0]            dq;
  logic [DVS_W-1:0]           rem;
  logic                       div_neg;
  logic [DCNT_W-1:0]          dcnt;

  // Shared magnitude multiplier, one half of the value operand per pass.
  logic [MB_LO_W-1:0]         mul_chunk;
  logic [MUL_W-1:0]           mul_out;
  assign mul_chunk = (state == S_MUL_HI) ? mul_b[VAL_W-1:MB_LO_W] : mul_b[MB_LO_W-1:0];
  assign mul_out   = MUL_W'(mul_a) * MUL_W'(mul_chunk);

  // Round to nearest, ties away from zero, on the magnitude; then restore the sign.
  logic [PROD_W:0]            rnd_sum;
  logic [MAG_W-1:0]           rnd_mag;
  logic signed [MRES_W-1:0]   rnd_val;
  assign rnd_sum = {1'b0, prod} + RND_HALF;
  assign rnd_mag = MAG_W'(rnd_sum >> FRACTION_BITS);
  assign rnd_val = mul_neg ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});

  // Small coefficient scaler shared by the square, numerator and tau steps.
  logic [CNT_W-1:0]           sc_coef;
  logic signed [SC_OP_W-1:0]  sc_op;
  logic signed [SC_W-1:0]     sc_prod;
  logic signed [ACC_W-1:0]    sc_term;

  always_comb begin
    sc_coef = '0;
    sc_op   = '0;
    case (state)
      S_SQUARE: begin
        sc_coef = CNT_W'(3);
        sc_op   = (SC_OP_W'(mres) <<< 1) - SC_OP_W'(ONE);
      end
      S_NUM_A: begin
        sc_coef = CNT_W'({n, 1'b0} - 1'b1);
        sc_op   = SC_OP_W'(mres);
      end
      S_NUM_B: begin
        sc_coef = n;
        sc_op   = SC_OP_W'(pi_before_previous);
      end
      S_TAU_A: begin
        sc_coef = n;
        sc_op   = SC_OP_W'(mres);
      end
      S_TAU_B: begin
        sc_coef = n + 1'b1;
        sc_op   = SC_OP_W'(pi_previous);
      end
      default: begin
        sc_coef = '0;
        sc_op   = '0;
      end
    endcase
  end

  assign sc_prod = $signed({1'b0, sc_coef}) * sc_op;
  assign sc_term = sc_prod[ACC_W-1:0];

  // Divider step: eight restoring steps on a six-bit remainder.
  logic [DVS_W-1:0]           divisor;
  logic [DQ_W-1:0]            dq_next;
  logic [DVS_W-1:0]           rem_next;
  assign divisor = DVS_W'(n - 1'b1);

  always_comb begin
    logic [DVS_W:0] t;
    dq_next  = dq;
    rem_next = rem;
    for (int i = 0; i < DIV_STEP; i++) begin
      t       = {rem_next, dq_next[DQ_W-1]};
      dq_next = dq_next << 1;
      if (t >= {1'b0, divisor}) begin
        rem_next   = DVS_W'(t - {1'b0, divisor});
        dq_next[0] = 1'b1;
      end else begin
        rem_next = t[DVS_W-1:0];
      end
    end
  end

  // Magnitude of the accumulator for the divider, signed quotient and saturation.
  logic [ACC_W-1:0]           acc_mag;
  logic [SAT_IN_W-1:0]        q_ext;
  logic signed [SAT_IN_W-1:0] q_signed;
  logic signed [VAL_W-1:0]    pi_sat;
  logic signed [VAL_W-1:0]    tau_sat;
  assign acc_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign q_ext    = {2'b00, dq};
  assign q_signed = div_neg ? -$signed(q_ext) : $signed(q_ext);
  assign pi_sat   = sat_val(q_signed);
  assign tau_sat  = sat_val(SAT_IN_W'(acc));

  // Operand of the next multiplication with the cosine.
  logic signed [VAL_W-1:0]    mul_b_start;
  always_comb begin
    if (state == S_PI) begin
      mul_b_start = pi_sat;
    end else if (n == CNT_W'(2)) begin
      mul_b_start = VAL_W'(held_cosine);
    end else begin
      mul_b_start = pi_previous;
    end
  end

  logic [CNT_W-1:0]           cfg_clamped;
  always_comb begin
    if (cfg_data < CNT_W'(2)) begin
      cfg_clamped = CNT_W'(2);
    end else if (cfg_data > CNT_W'(MAX_ORDERS)) begin
      cfg_clamped = CNT_W'(MAX_ORDERS);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      order_count        <= CNT_W'(MAX_ORDERS);
      n                  <= '0;
      held_cosine        <= '0;
      pi_previous        <= '0;
      pi_before_previous <= '0;
      m_tvalid           <= 1'b0;
      dcnt               <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        order_count <= cfg_clamped;
      end
      // In the emit state the output register is refilled instead of cleared.
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            held_cosine <= s_tdata[COS_W-1:0];
            n           <= CNT_W'(1);
            state       <= S_ORDER;
          end
        end

        S_ORDER: begin
          mul_a   <= held_cosine[COS_W-1] ? COS_W'(-held_cosine) : COS_W'(held_cosine);
          mul_b   <= mul_b_start[VAL_W-1] ? VAL_W'(-mul_b_start) : VAL_W'(mul_b_start);
          mul_neg <= held_cosine[COS_W-1] ^ mul_b_start[VAL_W-1];
          if (n == CNT_W'(1)) begin
            cur_pi <= ONE;
            acc    <= ACC_W'(held_cosine);
            state  <= S_EMIT;
          end else if (n == CNT_W'(2)) begin
            cur_pi  <= VAL_W'(held_cosine) + (VAL_W'(held_cosine) <<< 1);
            mul_sel <= MS_SQUARE;
            state   <= S_MUL_HI;
          end else begin
            mul_sel <= MS_PREV;
            state   <= S_MUL_HI;
          end
        end

        S_MUL_HI: begin
          prod  <= {mul_out, MB_LO_W'(0)};
          state <= S_MUL_LO;
        end

        S_MUL_LO: begin
          prod  <= prod + PROD_W'(mul_out);
          state <= S_MUL_RND;
        end

        S_MUL_RND: begin
          mres <= rnd_val;
          case (mul_sel)
            MS_SQUARE: state <= S_SQUARE;
            MS_PREV:   state <= S_NUM_A;
            MS_PI:     state <= S_TAU_A;
            default:   state <= S_IDLE;
          endcase
        end

        S_SQUARE: begin
          acc   <= sc_term;
          state <= S_EMIT;
        end

        S_NUM_A: begin
          acc   <= sc_term;
          state <= S_NUM_B;
        end

        S_NUM_B: begin
          acc   <= acc - sc_term;
          state <= S_DIV_SET;
        end

        S_DIV_SET: begin
          dq      <= DQ_W'(acc_mag);
          rem     <= '0;
          div_neg <= acc[ACC_W-1];
          dcnt    <= '0;
          state   <= S_DIV;
        end

        S_DIV: begin
          dq   <= dq_next;
          rem  <= rem_next;
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(DIV_ITERS - 1)) begin
            state <= S_PI;
          end
        end

        S_PI: begin
          cur_pi  <= pi_sat;
          mul_b   <= mul_b_start[VAL_W-1] ? VAL_W'(-mul_b_start) : VAL_W'(mul_b_start);
          mul_neg <= held_cosine[COS_W-1] ^ mul_b_start[VAL_W-1];
          mul_sel <= MS_PI;
          state   <= S_MUL_HI;
        end

        S_TAU_A: begin
          acc   <= sc_term;
          state <= S_TAU_B;
        end

        S_TAU_B: begin
          acc   <= acc - sc_term;
          state <= S_EMIT;
        end

        S_EMIT: begin
          // Wait until the output register is free or is being emptied this cycle.
          if (!m_tvalid || m_tready) begin
            m_tvalid           <= 1'b1;
            m_tdata            <= {2'b00, tau_sat, cur_pi, IDX_W'(n - 1'b1)};
            m_tlast            <= (n == order_count);
            pi_before_previous <= pi_previous;
            pi_previous        <= cur_pi;
            if (n == order_count) begin
              state <= S_IDLE;
            end else begin
              n     <= n + 1'b1;
              state <= S_ORDER;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The stored order count always lies in the supported range.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    order_count >= CNT_W'(2) && order_count <= CNT_W'(MAX_ORDERS))
    else $error("order_count out of range");

  // While a run is in progress the current order stays within the run.
  a_order_in_run: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> n >= CNT_W'(1) && n <= order_count)
    else $error("order counter outside the run");

  // The divider remainder never reaches the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < divisor)
    else $error("divider remainder not below divisor");

  // An accepted angle makes the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && n == CNT_W'(1))
    else $error("block still ready after accepting an angle");

  // A new beat carries the last-order mark exactly when the run ends.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && (!m_tvalid || m_tready) && n == order_count |=>
      state == S_IDLE && m_tvalid && m_tlast)
    else $error("final order did not close the run");

endmodule

`default_nettype wire
